// ===== sv/pdd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types, constants and the tile projection function for the polyline
// delta decoder.
// ----------------------------------------------------------------------------
package pdd_pkg;

    localparam int COORD_W  = 31;   // world coordinate width
    localparam int RUN_W    = 32;   // running coordinate / pixel width
    localparam int RAW_W    = 16;   // raw delta word width
    localparam int ZOOM_W   = 5;
    localparam int MAG_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 96; // 94 payload bits, padded to bytes
    localparam int OUT_DATA_W = 128;

    localparam logic [RUN_W-1:0]  DELTA_BIAS  = 32'h0008_0000;
    localparam logic [ZOOM_W-1:0] FULL_SHIFT  = 5'd23;
    localparam logic [ZOOM_W-1:0] SPARSE_ZOOM = 5'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_ZOOM     = 2'd2,
        CFG_MAG      = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DELTA = 1'b1
    } t_op;

    typedef struct packed {
        logic [COORD_W-1:0] tile_origin_x;
        logic [COORD_W-1:0] tile_origin_y;
        logic [ZOOM_W-1:0]  zoom_level;
        logic [MAG_W-1:0]   magnification;
    } t_cfg;

    typedef struct packed {
        t_op                operation;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [RAW_W-1:0]   delta_x_raw;
        logic [RAW_W-1:0]   delta_y_raw;
        logic               last_point;
    } t_item;

    typedef struct packed {
        logic [RUN_W-1:0] from_x;
        logic [RUN_W-1:0] from_y;
        logic [RUN_W-1:0] to_x;
        logic [RUN_W-1:0] to_y;
        logic             has_segment;
        logic             way_end;
    } t_seg;

    // Raw delta word to signed step: (raw << 4) - 2^19, modulo 2^32.
    function automatic logic [RUN_W-1:0] delta_step(input logic [RAW_W-1:0] raw);
        logic [RUN_W-1:0] scaled;
        scaled = {12'd0, raw, 4'd0};
        return scaled - DELTA_BIAS;
    endfunction

    // Shift both values down by (23 - zoom), zoom 23 and up shift by 0,
    // subtract and scale by magnification; everything wraps to 32 bits.
    function automatic logic [RUN_W-1:0] project(
        input logic [RUN_W-1:0]   coord,
        input logic [COORD_W-1:0] origin,
        input logic [ZOOM_W-1:0]  zoom,
        input logic [MAG_W-1:0]   mag
    );
        logic [ZOOM_W-1:0] sh;
        logic [RUN_W-1:0]  diff;
        logic [RUN_W+MAG_W-1:0] prod;
        sh   = (zoom >= FULL_SHIFT) ? '0 : (FULL_SHIFT - zoom);
        diff = (coord >> sh) - ({1'b0, origin} >> sh);
        prod = diff * mag;
        return prod[RUN_W-1:0];
    endfunction

endpackage

// ===== sv/polyline_delta_decode_project.sv =====
// ----------------------------------------------------------------------------
// polyline_delta_decode_project
// Decodes delta-coded polyline points, projects them into tile pixels and
// emits one segment request per point; below zoom 10 interior points are dropped.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | tdata {dy_raw,dx_raw,start_y,start_x}, tuser op,
//            |           | tlast last point of way
//  m_axis    | out       | tdata {to_y,to_x,from_y,from_x}, tuser has_segment,
//            |           | tlast way end
//  cfg       | in        | index 0..3 (origin x, origin y, zoom, magnification)
//
// Flow: a point request is registered on accept, then decoded and projected
// into the result register once that register is free. Throughput: one point
// per cycle while m_axis does not stall; the accumulator add, shift, subtract
// and 32x4 multiply all sit in the single stage between the two registers.
// Reset: synchronous, active low; clears coordinates, last pixel and config
// (magnification resets to 1). A stalled m_axis holds the result register and
// backs up into the input register before s_axis_tready drops.
// ----------------------------------------------------------------------------
module polyline_delta_decode_project (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // point requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [30:0] start_x, [61:31] start_y, [77:62] delta_x_raw,
    // [93:78] delta_y_raw, [95:94] zero
    input  logic [pdd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tuser,  // [0] operation
    input  logic                              s_axis_tlast,  // last_point

    // segment results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] from_x, [63:32] from_y, [95:64] to_x, [127:96] to_y
    output logic [pdd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,  // [0] has_segment
    output logic                              m_axis_tlast,  // way_end

    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pdd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pdd_pkg::COORD_W-1:0]       i_cfg_data
);

    pdd_pkg::t_cfg  w_cfg;
    pdd_pkg::t_item w_in_item, w_core_item;
    pdd_pkg::t_seg  w_core_seg, w_out_seg;
    logic           w_in_vld, w_take, w_emit, w_out_free, w_accept;

    // config is only written while idle by rule on the user, unchecked here, so it never needs to stall
    assign o_cfg_ready = 1'b1;

    pdd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (pdd_pkg::t_cfg_idx'(i_cfg_index)),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // unpack the slave payload
    always_comb begin
        w_in_item.operation   = pdd_pkg::t_op'(s_axis_tuser);
        w_in_item.start_x     = s_axis_tdata[30:0];
        w_in_item.start_y     = s_axis_tdata[61:31];
        w_in_item.delta_x_raw = s_axis_tdata[77:62];
        w_in_item.delta_y_raw = s_axis_tdata[93:78];
        w_in_item.last_point  = s_axis_tlast;
    end

    // the core consumes the held point whenever the result slot is free
    // (points dropped at low zoom need no slot, but waiting is harmless)
    assign w_take        = w_in_vld && w_out_free;
    assign s_axis_tready = !w_in_vld || w_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    pdd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_vld   (w_in_vld),
        .o_item  (w_core_item)
    );

    pdd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_item  (w_core_item),
        .i_take  (w_take),
        .o_emit  (w_emit),
        .o_seg   (w_core_seg)
    );

    pdd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take && w_emit),
        .i_seg   (w_core_seg),
        .i_ready (m_axis_tready),
        .o_vld   (m_axis_tvalid),
        .o_free  (w_out_free),
        .o_seg   (w_out_seg)
    );

    assign m_axis_tdata = {w_out_seg.to_y, w_out_seg.to_x,
                           w_out_seg.from_y, w_out_seg.from_x};
    assign m_axis_tuser = w_out_seg.has_segment;
    assign m_axis_tlast = w_out_seg.way_end;

    // an accepted request always lands in the input register
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_in_vld)
        else $error("accepted point request not held");

    // a held point that cannot move keeps its slot
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_vld && !w_take) |=> w_in_vld)
        else $error("stalled point request lost");

    // a way start carries no segment origin
    a_start_zero_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[63:0] == '0))
        else $error("start result with nonzero segment origin");

    // at low zoom only way ends produce delta segments
    a_low_zoom_sparse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser
         && (w_cfg.zoom_level < pdd_pkg::SPARSE_ZOOM)) |-> m_axis_tlast)
        else $error("interior point emitted at low zoom");

endmodule

// ===== sv/pdd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pdd_cfg_regs
// Configuration register file: tile origin, zoom and magnification.
// ----------------------------------------------------------------------------
module pdd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  pdd_pkg::t_cfg_idx             i_idx,
    input  logic [pdd_pkg::COORD_W-1:0]   i_data,
    output pdd_pkg::t_cfg                 o_cfg
);

    pdd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_origin_x <= '0;
            r_cfg.tile_origin_y <= '0;
            r_cfg.zoom_level    <= '0;
            r_cfg.magnification <= pdd_pkg::MAG_W'(1);
        end else if (i_wr) begin
            case (i_idx)
                pdd_pkg::CFG_ORIGIN_X: r_cfg.tile_origin_x <= i_data;
                pdd_pkg::CFG_ORIGIN_Y: r_cfg.tile_origin_y <= i_data;
                pdd_pkg::CFG_ZOOM:     r_cfg.zoom_level    <= i_data[pdd_pkg::ZOOM_W-1:0];
                pdd_pkg::CFG_MAG:      r_cfg.magnification <= i_data[pdd_pkg::MAG_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/pdd_in_stage.sv =====
// ----------------------------------------------------------------------------
// pdd_in_stage
// Input register: holds one point request until the core takes it.
// ----------------------------------------------------------------------------
module pdd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  pdd_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_vld,
    output pdd_pkg::t_item o_item
);

    logic           r_vld;
    pdd_pkg::t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== sv/pdd_core.sv =====
// ----------------------------------------------------------------------------
// pdd_core
// Running coordinate accumulator, tile projection and last-pixel state.
// ----------------------------------------------------------------------------
module pdd_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pdd_pkg::t_cfg  i_cfg,
    input  pdd_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_emit,
    output pdd_pkg::t_seg  o_seg
);

    logic [pdd_pkg::RUN_W-1:0] r_run_x, r_run_y, r_pix_x, r_pix_y;
    logic [pdd_pkg::RUN_W-1:0] n_run_x, n_run_y;
    logic [pdd_pkg::RUN_W-1:0] w_px, w_py;
    logic                      w_delta;

    assign w_delta = (i_item.operation == pdd_pkg::OP_DELTA);

    always_comb begin
        if (w_delta) begin
            n_run_x = r_run_x + pdd_pkg::delta_step(i_item.delta_x_raw);
            n_run_y = r_run_y + pdd_pkg::delta_step(i_item.delta_y_raw);
        end else begin
            n_run_x = {1'b0, i_item.start_x};
            n_run_y = {1'b0, i_item.start_y};
        end
    end

    assign w_px = pdd_pkg::project(n_run_x, i_cfg.tile_origin_x,
                                   i_cfg.zoom_level, i_cfg.magnification);
    assign w_py = pdd_pkg::project(n_run_y, i_cfg.tile_origin_y,
                                   i_cfg.zoom_level, i_cfg.magnification);

    // low zoom drops interior points of a way
    assign o_emit = !w_delta || i_item.last_point
                    || (i_cfg.zoom_level >= pdd_pkg::SPARSE_ZOOM);

    always_comb begin
        o_seg.from_x      = w_delta ? r_pix_x : '0;
        o_seg.from_y      = w_delta ? r_pix_y : '0;
        o_seg.to_x        = w_px;
        o_seg.to_y        = w_py;
        o_seg.has_segment = w_delta;
        o_seg.way_end     = i_item.last_point;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_x <= '0;
            r_run_y <= '0;
            r_pix_x <= '0;
            r_pix_y <= '0;
        end else if (i_take) begin
            r_run_x <= n_run_x;
            r_run_y <= n_run_y;
            if (o_emit) begin
                r_pix_x <= w_px;
                r_pix_y <= w_py;
            end
        end
    end

endmodule

// ===== sv/pdd_out_stage.sv =====
// ----------------------------------------------------------------------------
// pdd_out_stage
// Result register toward the master stream side.
// ----------------------------------------------------------------------------
module pdd_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  pdd_pkg::t_seg i_seg,
    input  logic          i_ready,
    output logic          o_vld,
    output logic          o_free,
    output pdd_pkg::t_seg o_seg
);

    logic          r_vld;
    pdd_pkg::t_seg r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seg <= i_seg;
        end
    end

    assign o_free = !r_vld || i_ready;
    assign o_vld  = r_vld;
    assign o_seg  = r_seg;

endmodule
